FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define WVC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define WVC_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/core/wvc_pkg.sv
// shared constants, angle tables and field widths of the velocity command block
package wvc_pkg;

  localparam int POS_W     = 14;
  localparam int HEAD_W    = 16;
  localparam int MODE_W    = 2;
  localparam int VEL_W     = 12;
  localparam int SPD_CFG_W = 10;

  localparam int HEAD_FRAC = 13;

  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int TAB_LEN = 24;

  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint HALFPI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30   = 64'sd652032874;

  localparam longint ATAN_Q30 [0:TAB_LEN-1] = '{
    64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158, 64'sd67021686,
    64'sd33543515,  64'sd16775850,  64'sd8388437,   64'sd4194282,   64'sd2097149,
    64'sd1048575,   64'sd524287,    64'sd262143,    64'sd131071,    64'sd65535,
    64'sd32767,     64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
    64'sd1023,      64'sd511,       64'sd255,       64'sd127
  };

  // speed profile constants
  localparam int SPEED_TOP     = 250;
  localparam int SQRT_GAIN     = 60;
  localparam int SPEED_BOOST   = 50;
  localparam int NEAR_LIMIT    = 100;
  localparam int MAX_SPEED_RST = 400;

  // digit-by-digit root lengths
  localparam int DIST_ROOT_W  = 15;
  localparam int SPEED_ROOT_W = 11;

  localparam logic [MODE_W-1:0] MODE_BOOST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROFILE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROOT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MAX     = 2'd3;

  // q30 angle to f fraction bits, rounded half up
  function automatic longint q30_to_f(longint v, int f);
    int s;
    s = 30 - f;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage

FILE: rtl/core/wvc_if.sv
// handshake channels of the velocity command block
interface wvc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [wvc_pkg::POS_W-1:0]    pos_x;
  logic signed [wvc_pkg::POS_W-1:0]    pos_y;
  logic signed [wvc_pkg::POS_W-1:0]    seg_start_x;
  logic signed [wvc_pkg::POS_W-1:0]    seg_start_y;
  logic signed [wvc_pkg::POS_W-1:0]    seg_goal_x;
  logic signed [wvc_pkg::POS_W-1:0]    seg_goal_y;
  logic signed [wvc_pkg::HEAD_W-1:0]   heading;
  logic        [wvc_pkg::MODE_W-1:0]   mode;

  modport source (output valid, pos_x, pos_y, seg_start_x, seg_start_y, seg_goal_x,
                  seg_goal_y, heading, mode, input ready);
  modport sink   (input valid, pos_x, pos_y, seg_start_x, seg_start_y, seg_goal_x,
                  seg_goal_y, heading, mode, output ready);
endinterface

interface wvc_vel_if;
  logic                               valid;
  logic                               ready;
  logic signed [wvc_pkg::VEL_W-1:0]   vel_fwd;
  logic signed [wvc_pkg::VEL_W-1:0]   vel_side;

  modport source (output valid, vel_fwd, vel_side, input ready);
  modport sink   (input valid, vel_fwd, vel_side, output ready);
endinterface

interface wvc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [wvc_pkg::SPD_CFG_W-1:0]        max_speed;

  modport source (output valid, max_speed, input ready);
  modport sink   (input valid, max_speed, output ready);
endinterface

FILE: rtl/core/waypoint_velocity_command_top.sv
// waypoint velocity command: pipelined distance, speed profile and cordic rotation
//
// usage
//   cmd: one item per command (robot position, segment start and goal, heading
//     in q3.13 radians, mode). accepted when cmd.valid and cmd.ready are high.
//   vel: one result item per command (vel_fwd, vel_side), in command order.
//   cfg: writes max_speed, always ready; write only while the block is idle.
// throughput
//   one item per cycle unless the output stalls; every stage advances together,
//   so the rate is set by the single shared stage enable, not by any loop
// pipeline
//   p0, p1, the phase b stages, p2, the phase c stages, p3, p4, the phase d
//   stages and the output register; each cordic has S = CORDIC_STAGES stages,
//   capped at 24. the distance roots take one digit per stage, the speed root
//   likewise, and each cordic takes one micro-rotation per stage
// reset
//   rst (synchronous) empties the pipe and sets max_speed to 400
// stall
//   when a result waits and vel.ready is low the whole pipe freezes and
//   cmd.ready drops; nothing is lost or repeated, bubbles travel as bubbles
`include "assert_macros.svh"

module waypoint_velocity_command_top #(
  parameter int ANGLE_FRAC_BITS = wvc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = wvc_pkg::CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  wvc_cmd_if.sink   cmd,
  wvc_vel_if.source vel,
  wvc_cfg_if.sink   cfg
);

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int SR  = (CORDIC_STAGES < wvc_pkg::TAB_LEN) ? CORDIC_STAGES : wvc_pkg::TAB_LEN;
  localparam int DRW = wvc_pkg::DIST_ROOT_W;
  localparam int SRW = wvc_pkg::SPEED_ROOT_W;
  localparam int LB  = (SR > DRW) ? SR : DRW;

  // angle words: vector result spans about +-4.9 rad, the difference +-9 rad
  localparam int ANG_W = F + 4;
  localparam int DIF_W = F + 5;
  localparam int VX_W  = 34;
  localparam int RX_W  = 43;
  localparam int PW    = wvc_pkg::POS_W;
  localparam int DW    = PW + 1;

  localparam longint PI_F  = wvc_pkg::q30_to_f(wvc_pkg::PI_Q30, F);
  localparam longint HPI_F = wvc_pkg::q30_to_f(wvc_pkg::HALFPI_Q30, F);

  localparam logic signed [ANG_W-1:0] PI_A   = ANG_W'(PI_F);
  localparam logic signed [DIF_W-1:0] PI_D   = DIF_W'(PI_F);
  localparam logic signed [DIF_W-1:0] NPI_D  = DIF_W'(-PI_F);
  localparam logic signed [DIF_W-1:0] TPI_D  = DIF_W'(2 * PI_F);
  localparam logic signed [DIF_W-1:0] HPI_D  = DIF_W'(HPI_F);
  localparam logic signed [DIF_W-1:0] NHPI_D = DIF_W'(-HPI_F);

  localparam logic [29:0] GAIN_U = 30'(wvc_pkg::GAIN_Q30);
  localparam logic signed [RX_W-1:0] HALF_R = RX_W'(64'sd536870912);

  localparam logic signed [RX_W-1:0] VMAX_R = RX_W'(2047);
  localparam logic signed [RX_W-1:0] VMIN_R = RX_W'(-2048);

  // global stage enable
  logic en;
  logic out_v;

  assign en        = !out_v || vel.ready;
  assign cmd.ready = en;

  // configuration register
  logic [wvc_pkg::SPD_CFG_W-1:0] max_speed;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= wvc_pkg::SPD_CFG_W'(wvc_pkg::MAX_SPEED_RST);
    end else if (cfg.valid) begin
      max_speed <= cfg.max_speed;
    end
  end

  // ---------------- stage p0: differences and heading rescale ----------------
  logic                    p0_v;
  logic signed [DW-1:0]    p0_dx, p0_dy, p0_ex, p0_ey;
  logic signed [DIF_W-1:0] p0_hd;
  logic [1:0]              p0_mode;
  logic signed [DIF_W-1:0] hd_s;

  generate
    if (F >= wvc_pkg::HEAD_FRAC) begin : g_hd_up
      assign hd_s = $signed({{(DIF_W-wvc_pkg::HEAD_W){cmd.heading[wvc_pkg::HEAD_W-1]}},
                             cmd.heading}) <<< (F - wvc_pkg::HEAD_FRAC);
    end else begin : g_hd_dn
      logic signed [wvc_pkg::HEAD_W-1:0] hs;
      assign hs   = cmd.heading >>> (wvc_pkg::HEAD_FRAC - F);
      assign hd_s = DIF_W'(hs);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
    end else if (en) begin
      p0_v <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_dx   <= DW'(cmd.seg_goal_x) - DW'(cmd.pos_x);
      p0_dy   <= DW'(cmd.seg_goal_y) - DW'(cmd.pos_y);
      p0_ex   <= DW'(cmd.seg_goal_x) - DW'(cmd.seg_start_x);
      p0_ey   <= DW'(cmd.seg_goal_y) - DW'(cmd.seg_start_y);
      p0_hd   <= hd_s;
      p0_mode <= cmd.mode;
    end
  end

  // ---------------- stage p1: squares and vectoring start ----------------
  logic signed [30:0]     sqx, sqy, sqex, sqey, sum_g, sum_s;
  logic signed [VX_W-1:0] vx_raw, vy_raw, vx_i, vy_i;
  logic signed [ANG_W-1:0] vz_i;

  assign sqx   = 31'(p0_dx) * 31'(p0_dx);
  assign sqy   = 31'(p0_dy) * 31'(p0_dy);
  assign sqex  = 31'(p0_ex) * 31'(p0_ex);
  assign sqey  = 31'(p0_ey) * 31'(p0_ey);
  assign sum_g = sqx + sqy;
  assign sum_s = sqex + sqey;

  assign vx_raw = $signed({{(VX_W-DW-16){p0_dx[DW-1]}}, p0_dx, 16'd0});
  assign vy_raw = $signed({{(VX_W-DW-16){p0_dy[DW-1]}}, p0_dy, 16'd0});

  // left half plane: flip the vector and start from +-pi
  always_comb begin
    vx_i = vx_raw;
    vy_i = vy_raw;
    vz_i = '0;
    if (p0_dx[DW-1]) begin
      vx_i = -vx_raw;
      vy_i = -vy_raw;
      vz_i = p0_dy[DW-1] ? -PI_A : PI_A;
    end
  end

  // phase b arrays: index 0 is the p1 register
  logic                    b_v    [0:LB];
  logic [29:0]             b_qg   [0:LB];
  logic [29:0]             b_qs   [0:LB];
  logic [DRW+1:0]          b_mg   [0:LB];
  logic [DRW+1:0]          b_ms   [0:LB];
  logic [DRW-1:0]          b_rg   [0:LB];
  logic [DRW-1:0]          b_rs   [0:LB];
  logic signed [VX_W-1:0]  b_x    [0:LB];
  logic signed [VX_W-1:0]  b_y    [0:LB];
  logic signed [ANG_W-1:0] b_z    [0:LB];
  logic                    b_zero [0:LB];
  logic signed [DIF_W-1:0] b_hd   [0:LB];
  logic [1:0]              b_mode [0:LB];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v[0] <= 1'b0;
    end else if (en) begin
      b_v[0] <= p0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_qg[0]   <= sum_g[29:0];
      b_qs[0]   <= sum_s[29:0];
      b_mg[0]   <= '0;
      b_ms[0]   <= '0;
      b_rg[0]   <= '0;
      b_rs[0]   <= '0;
      b_x[0]    <= vx_i;
      b_y[0]    <= vy_i;
      b_z[0]    <= vz_i;
      b_zero[0] <= (p0_dx == '0) && (p0_dy == '0);
      b_hd[0]   <= p0_hd;
      b_mode[0] <= p0_mode;
    end
  end

  // ---------------- phase b: distance roots and vectoring cordic ----------------
  generate
    for (genvar k = 0; k < LB; k++) begin : g_b
      logic [DRW+1:0]          mg_n, ms_n;
      logic [DRW-1:0]          rg_n, rs_n;
      logic signed [VX_W-1:0]  x_n, y_n;
      logic signed [ANG_W-1:0] z_n;

      if (k < DRW) begin : g_root
        logic [DRW+1:0] mg_t, ms_t, tg, ts;
        always_comb begin
          mg_t = {b_mg[k][DRW-1:0], b_qg[k][29:28]};
          ms_t = {b_ms[k][DRW-1:0], b_qs[k][29:28]};
          tg   = {b_rg[k], 2'b01};
          ts   = {b_rs[k], 2'b01};
          if (mg_t >= tg) begin
            mg_n = mg_t - tg;
            rg_n = {b_rg[k][DRW-2:0], 1'b1};
          end else begin
            mg_n = mg_t;
            rg_n = {b_rg[k][DRW-2:0], 1'b0};
          end
          if (ms_t >= ts) begin
            ms_n = ms_t - ts;
            rs_n = {b_rs[k][DRW-2:0], 1'b1};
          end else begin
            ms_n = ms_t;
            rs_n = {b_rs[k][DRW-2:0], 1'b0};
          end
        end
      end else begin : g_root_hold
        assign mg_n = b_mg[k];
        assign ms_n = b_ms[k];
        assign rg_n = b_rg[k];
        assign rs_n = b_rs[k];
      end

      if (k < SR) begin : g_vec
        localparam logic signed [ANG_W-1:0] AT =
          ANG_W'(wvc_pkg::q30_to_f(wvc_pkg::ATAN_Q30[k], F));
        always_comb begin
          if (b_y[k] > 0) begin
            x_n = b_x[k] + (b_y[k] >>> k);
            y_n = b_y[k] - (b_x[k] >>> k);
            z_n = b_z[k] + AT;
          end else begin
            x_n = b_x[k] - (b_y[k] >>> k);
            y_n = b_y[k] + (b_x[k] >>> k);
            z_n = b_z[k] - AT;
          end
        end
      end else begin : g_vec_hold
        assign x_n = b_x[k];
        assign y_n = b_y[k];
        assign z_n = b_z[k];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          b_v[k+1] <= 1'b0;
        end else if (en) begin
          b_v[k+1] <= b_v[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          b_qg[k+1]   <= {b_qg[k][27:0], 2'b00};
          b_qs[k+1]   <= {b_qs[k][27:0], 2'b00};
          b_mg[k+1]   <= mg_n;
          b_ms[k+1]   <= ms_n;
          b_rg[k+1]   <= rg_n;
          b_rs[k+1]   <= rs_n;
          b_x[k+1]    <= x_n;
          b_y[k+1]    <= y_n;
          b_z[k+1]    <= z_n;
          b_zero[k+1] <= b_zero[k];
          b_hd[k+1]   <= b_hd[k];
          b_mode[k+1] <= b_mode[k];
        end
      end
    end
  endgenerate

  // ---------------- stage p2: speed radicand and wrapped angle difference ----------------
  logic signed [ANG_W-1:0] alpha;
  logic signed [DIF_W-1:0] d_raw, d_wrap;

  assign alpha = b_zero[LB] ? '0 : b_z[LB];
  assign d_raw = DIF_W'(alpha) - b_hd[LB];

  always_comb begin
    d_wrap = d_raw;
    if (d_raw > PI_D) begin
      d_wrap = d_raw - TPI_D;
    end else if (d_raw < NPI_D) begin
      d_wrap = d_raw + TPI_D;
    end
  end

  // phase c arrays: index 0 is the p2 register
  logic                    c_v    [0:SRW];
  logic [2*SRW-1:0]        c_q    [0:SRW];
  logic [SRW+1:0]          c_m    [0:SRW];
  logic [SRW-1:0]          c_r    [0:SRW];
  logic [DRW-1:0]          c_dg   [0:SRW];
  logic [DRW-1:0]          c_ds   [0:SRW];
  logic signed [DIF_W-1:0] c_diff [0:SRW];
  logic [1:0]              c_mode [0:SRW];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (en) begin
      c_v[0] <= b_v[LB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_q[0]    <= (2*SRW)'(b_rg[LB]) * (2*SRW)'(wvc_pkg::SQRT_GAIN);
      c_m[0]    <= '0;
      c_r[0]    <= '0;
      c_dg[0]   <= b_rg[LB];
      c_ds[0]   <= b_rs[LB];
      c_diff[0] <= d_wrap;
      c_mode[0] <= b_mode[LB];
    end
  end

  // ---------------- phase c: speed root ----------------
  generate
    for (genvar k = 0; k < SRW; k++) begin : g_c
      logic [SRW+1:0] m_t, t, m_n;
      logic [SRW-1:0] r_n;

      always_comb begin
        m_t = {c_m[k][SRW-1:0], c_q[k][2*SRW-1:2*SRW-2]};
        t   = {c_r[k], 2'b01};
        if (m_t >= t) begin
          m_n = m_t - t;
          r_n = {c_r[k][SRW-2:0], 1'b1};
        end else begin
          m_n = m_t;
          r_n = {c_r[k][SRW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          c_v[k+1] <= 1'b0;
        end else if (en) begin
          c_v[k+1] <= c_v[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          c_q[k+1]    <= {c_q[k][2*SRW-3:0], 2'b00};
          c_m[k+1]    <= m_n;
          c_r[k+1]    <= r_n;
          c_dg[k+1]   <= c_dg[k];
          c_ds[k+1]   <= c_ds[k];
          c_diff[k+1] <= c_diff[k];
          c_mode[k+1] <= c_mode[k];
        end
      end
    end
  endgenerate

  // ---------------- stage p3: speed select and half-plane fold ----------------
  logic                    p3_v;
  logic [SRW-1:0]          p3_speed;
  logic                    p3_neg;
  logic signed [DIF_W-1:0] p3_diff;
  logic [SRW-1:0]          spd_sel;
  logic                    neg_sel;
  logic signed [DIF_W-1:0] diff_sel;
  logic [DRW:0]            dg2;

  assign dg2 = {c_dg[SRW], 1'b0};

  always_comb begin
    case (c_mode[SRW])
      wvc_pkg::MODE_MAX:  spd_sel = SRW'(max_speed);
      wvc_pkg::MODE_ROOT: spd_sel = c_r[SRW];
      wvc_pkg::MODE_BOOST, wvc_pkg::MODE_PROFILE: begin
        if (dg2 > (DRW+1)'(c_ds[SRW])) begin
          spd_sel = SRW'(wvc_pkg::SPEED_TOP);
        end else if (c_dg[SRW] > DRW'(wvc_pkg::NEAR_LIMIT)) begin
          spd_sel = SRW'(wvc_pkg::SPEED_TOP);
        end else if (c_mode[SRW] == wvc_pkg::MODE_BOOST) begin
          spd_sel = c_r[SRW] + SRW'(wvc_pkg::SPEED_BOOST);
        end else begin
          spd_sel = c_r[SRW];
        end
      end
      default: spd_sel = c_r[SRW];
    endcase
  end

  always_comb begin
    neg_sel  = 1'b0;
    diff_sel = c_diff[SRW];
    if (c_diff[SRW] > HPI_D) begin
      neg_sel  = 1'b1;
      diff_sel = c_diff[SRW] - PI_D;
    end else if (c_diff[SRW] < NHPI_D) begin
      neg_sel  = 1'b1;
      diff_sel = c_diff[SRW] + PI_D;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= c_v[SRW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_speed <= spd_sel;
      p3_neg   <= neg_sel;
      p3_diff  <= diff_sel;
    end
  end

  // ---------------- stage p4: speed times cordic gain ----------------
  logic                    p4_v;
  logic [SRW+29:0]         p4_prod;
  logic                    p4_neg;
  logic signed [DIF_W-1:0] p4_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (en) begin
      p4_v <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_prod <= p3_speed * GAIN_U;
      p4_neg  <= p3_neg;
      p4_diff <= p3_diff;
    end
  end

  // ---------------- phase d: rotation cordic ----------------
  logic                    r_v [0:SR];
  logic signed [RX_W-1:0]  r_x [0:SR];
  logic signed [RX_W-1:0]  r_y [0:SR];
  logic signed [DIF_W-1:0] r_z [0:SR];
  logic signed [RX_W-1:0]  x_start;

  assign x_start = p4_neg ? -$signed(RX_W'(p4_prod)) : $signed(RX_W'(p4_prod));
  assign r_v[0]  = p4_v;
  assign r_x[0]  = x_start;
  assign r_y[0]  = '0;
  assign r_z[0]  = p4_diff;

  generate
    for (genvar k = 0; k < SR; k++) begin : g_d
      localparam logic signed [DIF_W-1:0] AT =
        DIF_W'(wvc_pkg::q30_to_f(wvc_pkg::ATAN_Q30[k], F));
      logic signed [RX_W-1:0]  x_n, y_n;
      logic signed [DIF_W-1:0] z_n;

      always_comb begin
        if (r_z[k] >= 0) begin
          x_n = r_x[k] - (r_y[k] >>> k);
          y_n = r_y[k] + (r_x[k] >>> k);
          z_n = r_z[k] - AT;
        end else begin
          x_n = r_x[k] + (r_y[k] >>> k);
          y_n = r_y[k] - (r_x[k] >>> k);
          z_n = r_z[k] + AT;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          r_v[k+1] <= 1'b0;
        end else if (en) begin
          r_v[k+1] <= r_v[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          r_x[k+1] <= x_n;
          r_y[k+1] <= y_n;
          r_z[k+1] <= z_n;
        end
      end
    end
  endgenerate

  // ---------------- output: round half away from zero, saturate ----------------
  logic signed [RX_W-1:0] rx_rnd, ry_rnd;
  logic signed [RX_W-1:0] rx_neg, ry_neg;
  logic signed [wvc_pkg::VEL_W-1:0] fwd_sat, side_sat;

  assign rx_neg = -r_x[SR];
  assign ry_neg = -r_y[SR];
  assign rx_rnd = r_x[SR][RX_W-1] ? -((rx_neg + HALF_R) >>> 30) : ((r_x[SR] + HALF_R) >>> 30);
  assign ry_rnd = r_y[SR][RX_W-1] ? -((ry_neg + HALF_R) >>> 30) : ((r_y[SR] + HALF_R) >>> 30);

  always_comb begin
    if (rx_rnd > VMAX_R) begin
      fwd_sat = VMAX_R[wvc_pkg::VEL_W-1:0];
    end else if (rx_rnd < VMIN_R) begin
      fwd_sat = VMIN_R[wvc_pkg::VEL_W-1:0];
    end else begin
      fwd_sat = rx_rnd[wvc_pkg::VEL_W-1:0];
    end
    if (ry_rnd > VMAX_R) begin
      side_sat = VMAX_R[wvc_pkg::VEL_W-1:0];
    end else if (ry_rnd < VMIN_R) begin
      side_sat = VMIN_R[wvc_pkg::VEL_W-1:0];
    end else begin
      side_sat = ry_rnd[wvc_pkg::VEL_W-1:0];
    end
  end

  logic signed [wvc_pkg::VEL_W-1:0] out_fwd, out_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= r_v[SR];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_fwd  <= fwd_sat;
      out_side <= side_sat;
    end
  end

  assign vel.valid    = out_v;
  assign vel.vel_fwd  = out_fwd;
  assign vel.vel_side = out_side;

  // ---------------- assertions ----------------
  // a frozen pipe must not move its first valid bit
  `WVC_ASSERT_NEXT(a_stall_freeze, clk, rst, !en, $stable(p0_v) && $stable(b_v[0]),
                   "pipe advanced during a stall")
  // wrapped difference stays within one turn
  `WVC_ASSERT(a_wrap_range, clk, rst, !c_v[0] || (c_diff[0] <= PI_D && c_diff[0] >= NPI_D),
              "angle difference outside +-pi after wrap")
  // folded rotation angle within the cordic convergence range
  `WVC_ASSERT(a_fold_range, clk, rst, !p3_v || (p3_diff <= HPI_D && p3_diff >= NHPI_D),
              "rotation angle outside +-pi/2 after fold")

endmodule

FILE: verif/tb.sv
// testbench top: directed and random commands checked against a velocity predictor
`timescale 1ns / 1ps

module tb;

  localparam int AFB = wvc_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int STG = (wvc_pkg::CORDIC_STAGES_DEF < wvc_pkg::TAB_LEN) ?
                       wvc_pkg::CORDIC_STAGES_DEF : wvc_pkg::TAB_LEN;
  localparam int PW  = wvc_pkg::POS_W;
  localparam int HW  = wvc_pkg::HEAD_W;
  localparam int MW  = wvc_pkg::MODE_W;
  localparam int VW  = wvc_pkg::VEL_W;
  localparam int CW  = wvc_pkg::SPD_CFG_W;
  // pipe depth from accept to result
  localparam int PIPE_LAT = 2 + ((STG > 15) ? STG : 15) + 12 + 2 + STG + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wvc_cmd_if cmd ();
  wvc_vel_if vel ();
  wvc_cfg_if cfg ();

  waypoint_velocity_command_top u_dut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .vel(vel.source), .cfg(cfg.sink)
  );

  always #6 clk = ~clk;

  typedef struct packed {
    logic signed [PW-1:0] px, py, sx, sy, gx, gy;
    logic signed [HW-1:0] hd;
    logic [MW-1:0]        mode;
  } cmd_item_t;

  typedef struct packed {
    logic signed [VW-1:0] fwd;
    logic signed [VW-1:0] side;
  } vel_item_t;

  vel_item_t   vel_expected_q[$];
  logic [CW-1:0] speed_limit = CW'(wvc_pkg::MAX_SPEED_RST);
  int          fail_cnt = 0;
  bit          stall_on = 1'b1;   // random idling enabled
  int          hold_cycles = 0;   // long receiver hold-off when nonzero

  // fixed point helpers, all floor shifts
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint ang_q(longint v);
    int s;
    s = 30 - AFB;
    return fshr(v + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint goal_bearing(longint dy, longint dx);
    longint x, y, z, t;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? ang_q(wvc_pkg::PI_Q30) : -ang_q(wvc_pkg::PI_Q30);
    end
    for (int i = 0; i < STG; i++) begin
      if (y > 0) begin
        t = x + fshr(y, i);
        y = y - fshr(x, i);
        z += ang_q(wvc_pkg::ATAN_Q30[i]);
      end else begin
        t = x - fshr(y, i);
        y = y + fshr(x, i);
        z -= ang_q(wvc_pkg::ATAN_Q30[i]);
      end
      x = t;
    end
    return z;
  endfunction

  function automatic logic signed [VW-1:0] round_sat(longint v);
    longint r;
    r = (v >= 0) ? fshr(v + (64'sd1 <<< 29), 30) : -fshr(-v + (64'sd1 <<< 29), 30);
    if (r > 2047) r = 2047;
    if (r < -2048) r = -2048;
    return r[VW-1:0];
  endfunction

  function automatic vel_item_t predict_velocity(cmd_item_t c);
    longint dx, dy, ex, ey, dgoal, dseg, spd, hd, pi_f, hpi_f, diff, x, y, t;
    vel_item_t r;
    dx = longint'(c.gx) - longint'(c.px);
    dy = longint'(c.gy) - longint'(c.py);
    ex = longint'(c.gx) - longint'(c.sx);
    ey = longint'(c.gy) - longint'(c.sy);
    dgoal = int_sqrt(dx * dx + dy * dy);
    dseg  = int_sqrt(ex * ex + ey * ey);
    pi_f  = ang_q(wvc_pkg::PI_Q30);
    hpi_f = ang_q(wvc_pkg::HALFPI_Q30);
    if (c.mode == wvc_pkg::MODE_MAX) begin
      spd = longint'(speed_limit);
    end else if (c.mode == wvc_pkg::MODE_ROOT) begin
      spd = int_sqrt(longint'(wvc_pkg::SQRT_GAIN) * dgoal);
    end else if (2 * dgoal > dseg) begin
      spd = longint'(wvc_pkg::SPEED_TOP);
    end else begin
      spd = int_sqrt(longint'(wvc_pkg::SQRT_GAIN) * dgoal) +
            ((c.mode == wvc_pkg::MODE_BOOST) ? longint'(wvc_pkg::SPEED_BOOST) : 64'sd0);
      if (dgoal > longint'(wvc_pkg::NEAR_LIMIT)) spd = longint'(wvc_pkg::SPEED_TOP);
    end
    hd = longint'(c.hd);
    if (AFB >= wvc_pkg::HEAD_FRAC) hd = hd * (64'sd1 <<< (AFB - wvc_pkg::HEAD_FRAC));
    else hd = fshr(hd, wvc_pkg::HEAD_FRAC - AFB);
    diff = goal_bearing(dy, dx) - hd;
    if (diff > pi_f) diff -= 2 * pi_f;
    else if (diff < -pi_f) diff += 2 * pi_f;
    x = spd * wvc_pkg::GAIN_Q30;
    y = 0;
    if (diff > hpi_f) begin
      x = -x;
      diff -= pi_f;
    end else if (diff < -hpi_f) begin
      x = -x;
      diff += pi_f;
    end
    for (int i = 0; i < STG; i++) begin
      if (diff >= 0) begin
        t = x - fshr(y, i);
        y = y + fshr(x, i);
        diff -= ang_q(wvc_pkg::ATAN_Q30[i]);
      end else begin
        t = x + fshr(y, i);
        y = y - fshr(x, i);
        diff += ang_q(wvc_pkg::ATAN_Q30[i]);
      end
      x = t;
    end
    r.fwd  = round_sat(x);
    r.side = round_sat(y);
    return r;
  endfunction

  // initial values on every input
  initial begin
    cmd.valid = 1'b0;
    {cmd.pos_x, cmd.pos_y, cmd.seg_start_x, cmd.seg_start_y} = '0;
    {cmd.seg_goal_x, cmd.seg_goal_y, cmd.heading, cmd.mode} = '0;
    vel.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.max_speed = '0;
  end

  // receiver: random idle bursts, or a long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        vel.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        vel.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        vel.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    vel_item_t exp_v;
    if (!rst && vel.valid && vel.ready) begin
      if (vel_expected_q.size() == 0) begin
        $error("result item with nothing expected: fwd %0d side %0d", vel.vel_fwd, vel.vel_side);
        fail_cnt++;
      end else begin
        exp_v = vel_expected_q.pop_front();
        if (vel.vel_fwd !== exp_v.fwd) begin
          $error("vel_fwd expected %0d actual %0d", exp_v.fwd, vel.vel_fwd);
          fail_cnt++;
        end
        if (vel.vel_side !== exp_v.side) begin
          $error("vel_side expected %0d actual %0d", exp_v.side, vel.vel_side);
          fail_cnt++;
        end
      end
    end
  end

  // drive one command item, optional idle burst first; expectation made on accept
  task automatic send_cmd(cmd_item_t c);
    if (stall_on && $urandom_range(0, 4) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.pos_x <= c.px;
    cmd.pos_y <= c.py;
    cmd.seg_start_x <= c.sx;
    cmd.seg_start_y <= c.sy;
    cmd.seg_goal_x <= c.gx;
    cmd.seg_goal_y <= c.gy;
    cmd.heading <= c.hd;
    cmd.mode <= c.mode;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    vel_expected_q.push_back(predict_velocity(c));
    @(negedge clk);
  endtask

  task automatic end_burst();
    cmd.valid <= 1'b0;
  endtask

  // wait for all results, then let the pipe settle
  task automatic drain();
    end_burst();
    while (vel_expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  task automatic write_max_speed(logic [CW-1:0] v);
    cfg.valid <= 1'b1;
    cfg.max_speed <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    speed_limit = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic cmd_item_t mk(int px, int py, int sx, int sy, int gx, int gy,
                                   int hd, logic [MW-1:0] md);
    cmd_item_t c;
    c.px = PW'(px); c.py = PW'(py); c.sx = PW'(sx); c.sy = PW'(sy);
    c.gx = PW'(gx); c.gy = PW'(gy);
    c.hd = HW'(hd); c.mode = md;
    return c;
  endfunction

  function automatic logic signed [PW-1:0] rpos();
    return PW'($urandom);
  endfunction

  // random command; mostly sane paths near the goal, some anywhere
  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int sel;
    c.px = rpos(); c.py = rpos(); c.sx = rpos(); c.sy = rpos();
    c.gx = rpos(); c.gy = rpos();
    c.hd = HW'($urandom);
    c.mode = MW'($urandom);
    sel = $urandom_range(0, 3);
    if (sel < 3) begin
      // keep coordinates inside the field range
      if (c.px > 7000 || c.px < -7000) c.px = c.px / 2;
      if (c.py > 7000 || c.py < -7000) c.py = c.py / 2;
      // goal near the robot so that the root profile is reached
      c.gx = PW'(int'(c.px) + int'($urandom_range(0, 300)) - 150);
      c.gy = PW'(int'(c.py) + int'($urandom_range(0, 300)) - 150);
      c.sx = PW'(int'(c.gx) + int'($urandom_range(0, 1200)) - 600);
      c.sy = PW'(int'(c.gy) + int'($urandom_range(0, 1200)) - 600);
      c.hd = HW'(int'($urandom_range(0, 51472)) - 25736);
    end
    return c;
  endfunction

  // extremes, every mode, robot on goal, wrap and fold of the angle
  task automatic test_directed();
    send_cmd(mk(0, 0, 0, 0, 0, 0, 0, wvc_pkg::MODE_BOOST));
    send_cmd(mk(0, 0, 0, 0, 0, 0, 0, wvc_pkg::MODE_PROFILE));
    send_cmd(mk(0, 0, 0, 0, 0, 0, 0, wvc_pkg::MODE_ROOT));
    send_cmd(mk(0, 0, 0, 0, 0, 0, 0, wvc_pkg::MODE_MAX));
    send_cmd(mk(-8192, -8192, 8191, 8191, 8191, 8191, 25736, wvc_pkg::MODE_ROOT));
    send_cmd(mk(8191, 8191, -8192, -8192, -8192, -8192, -25736, wvc_pkg::MODE_ROOT));
    send_cmd(mk(8191, -8192, 8191, -8192, -8192, 8191, 0, wvc_pkg::MODE_MAX));
    send_cmd(mk(0, 0, -100, 0, 100, 0, 0, wvc_pkg::MODE_BOOST));
    send_cmd(mk(60, 0, -100, 0, 100, 0, 0, wvc_pkg::MODE_BOOST));
    send_cmd(mk(60, 0, -100, 0, 100, 0, 0, wvc_pkg::MODE_PROFILE));
    send_cmd(mk(0, 0, -1000, 0, 300, 0, 0, wvc_pkg::MODE_BOOST));
    send_cmd(mk(0, 0, 0, 0, -50, 0, 0, wvc_pkg::MODE_PROFILE));
    send_cmd(mk(0, 0, 0, 0, -50, -1, 0, wvc_pkg::MODE_PROFILE));
    send_cmd(mk(0, 0, 0, 0, 0, 40, 0, wvc_pkg::MODE_ROOT));
    send_cmd(mk(0, 0, 0, 0, 0, -40, 0, wvc_pkg::MODE_ROOT));
    send_cmd(mk(0, 0, 0, 0, 40, 40, -32768, wvc_pkg::MODE_MAX));
    send_cmd(mk(0, 0, 0, 0, 40, -40, 32767, wvc_pkg::MODE_MAX));
    send_cmd(mk(0, 0, 0, 0, -40, 40, -25736, wvc_pkg::MODE_MAX));
    send_cmd(mk(0, 0, 0, 0, 10, 0, 16000, wvc_pkg::MODE_ROOT));
    send_cmd(mk(0, 0, 0, 0, 10, 0, -16000, wvc_pkg::MODE_ROOT));
    send_cmd(mk(5, 5, 5, 5, 5, 5, -1, wvc_pkg::MODE_BOOST));
    drain();
  endtask

  // max_speed across its extremes, mode 3 heavy
  task automatic test_max_speed();
    logic [CW-1:0] vals [4] = '{10'd0, 10'd1023, 10'd1, 10'd512};
    cmd_item_t c;
    foreach (vals[k]) begin
      write_max_speed(vals[k]);
      repeat (15) begin
        c = rand_cmd();
        c.mode = ($urandom_range(0, 2) != 0) ? wvc_pkg::MODE_MAX : c.mode;
        send_cmd(c);
      end
      drain();
    end
    write_max_speed(CW'($urandom));
  endtask

  // long receiver hold-off while commands keep coming
  task automatic test_backpressure();
    hold_cycles = 3 * PIPE_LAT;
    repeat (120) send_cmd(rand_cmd());
    drain();
  endtask

  task automatic test_random();
    repeat (550) send_cmd(rand_cmd());
    drain();
    write_max_speed(10'd400);
    stall_on = 1'b0;   // closing stretch without idling
    repeat (100) send_cmd(rand_cmd());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);
    test_directed();
    test_max_speed();
    test_backpressure();
    test_random();
    if (fail_cnt == 0 && vel_expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule

FILE: waypoint_velocity_command_top.f
+incdir+rtl/core
rtl/core/wvc_pkg.sv
rtl/core/wvc_if.sv
rtl/core/waypoint_velocity_command_top.sv
verif/tb.sv
